// ===== sv/lpp_pkg.sv =====
// Shared constants, codes and payload types of the line-to-plane projection block.
`timescale 1ns / 1ps
`default_nettype none
package lpp_pkg;

   // Field widths.
   localparam int COORD_W   = 32;
   localparam int DIR_W     = 16;
   localparam int DIR_OUT_W = 48;
   localparam int DIR_FRAC  = DIR_W - 2;

   // Widths of the intermediate terms.
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIR_W;
   localparam int UDN_W   = PROD_W + 2;
   localparam int CROSS_W = PROD_W + 1;
   localparam int LPROD_W = DIFF_W + DIR_W;
   localparam int LTP_W   = LPROD_W + 2;
   localparam int DPROD_W = DIR_W + CROSS_W;
   localparam int DDIF_W  = DPROD_W + 1;
   localparam int DEN_W   = PROD_W;
   localparam int NUM_W   = LTP_W + DIR_W;
   localparam int QUOT_W  = COORD_W + 2;
   localparam int SUM_W   = QUOT_W + 2;
   localparam int DIV_LAT = QUOT_W + 1;

   // Register file.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z   = 3'd5;

   // Case codes.
   localparam logic [1:0] CASE_INTERCEPT = 2'd0;
   localparam logic [1:0] CASE_IN_PLANE  = 2'd1;
   localparam logic [1:0] CASE_PARALLEL  = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] plane_point_x;
      logic signed [COORD_W-1:0] plane_point_y;
      logic signed [COORD_W-1:0] plane_point_z;
      logic signed [DIR_W-1:0]   normal_x;
      logic signed [DIR_W-1:0]   normal_y;
      logic signed [DIR_W-1:0]   normal_z;
   } lpp_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]   proj_point_x;
      logic signed [COORD_W-1:0]   proj_point_y;
      logic signed [COORD_W-1:0]   proj_point_z;
      logic signed [DIR_OUT_W-1:0] proj_dir_x;
      logic signed [DIR_OUT_W-1:0] proj_dir_y;
      logic signed [DIR_OUT_W-1:0] proj_dir_z;
      logic [1:0]                  case_code;
      logic                        saturated;
   } lpp_rsp_type;

   // Stored line.
   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic signed [DIR_W-1:0]   dir_x;
      logic signed [DIR_W-1:0]   dir_y;
      logic signed [DIR_W-1:0]   dir_z;
   } lpp_line_type;

   // Data that rides alongside the dividers.
   typedef struct packed {
      logic [2:0]                  neg;
      logic [1:0]                  code;
      logic signed [DIR_OUT_W-1:0] dir_x;
      logic signed [DIR_OUT_W-1:0] dir_y;
      logic signed [DIR_OUT_W-1:0] dir_z;
   } lpp_side_type;

   // Front-end result handed to the dividers.
   typedef struct packed {
      logic [NUM_W-1:0] num_x;
      logic [NUM_W-1:0] num_y;
      logic [NUM_W-1:0] num_z;
      logic [DEN_W-1:0] den;
      lpp_side_type     side;
   } lpp_work_type;

endpackage
`default_nettype wire

// ===== sv/line_plane_projection_top.sv =====
// Top level of the line-to-plane projection: registers, pipeline and output stage.
//
//   channel   ports                       transfer when
//   --------  --------------------------  ---------------------------
//   request   start, busy, req_data       start high and busy low
//   result    rsp_valid, rsp_data         rsp_valid high (one cycle)
//   config    csr_we, csr_index, csr_wdata csr_we high
//
// A new item can enter on every clock; busy is held low.
// Each result passes through six front-end stages, the 35-stage divider (an
// entry stage, then one quotient bit per stage) and the output register.
// Reset clears the valid bits and the line registers to zero.
// The result side has no back-pressure, so the pipeline never stops.
`timescale 1ns / 1ps
`default_nettype none
module line_plane_projection_top
   import lpp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire lpp_req_type          req_data,
   output logic                      rsp_valid,
   output lpp_rsp_type               rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COORD_W-1:0]   csr_wdata
);

   lpp_line_type line_ff;

   logic         front_valid;
   lpp_work_type front_work;

   logic [QUOT_W-1:0] quot [3];
   logic              ovf  [3];

   logic         side_valid_ff [DIV_LAT];
   lpp_side_type side_ff       [DIV_LAT];

   logic         rsp_valid_ff;
   lpp_rsp_type  rsp_data_ff, rsp_data_in;

   assign busy = 1'b0;

   // Line registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POINT_X: line_ff.point_x <= csr_wdata;
            CSR_POINT_Y: line_ff.point_y <= csr_wdata;
            CSR_POINT_Z: line_ff.point_z <= csr_wdata;
            CSR_DIR_X:   line_ff.dir_x   <= csr_wdata[DIR_W-1:0];
            CSR_DIR_Y:   line_ff.dir_y   <= csr_wdata[DIR_W-1:0];
            CSR_DIR_Z:   line_ff.dir_z   <= csr_wdata[DIR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lpp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_req    (req_data),
      .line      (line_ff),
      .out_valid (front_valid),
      .out_work  (front_work)
   );

   lpp_div u_div_x (
      .clock    (clock),
      .in_num   (front_work.num_x),
      .in_den   (front_work.den),
      .out_quot (quot[0]),
      .out_ovf  (ovf[0])
   );

   lpp_div u_div_y (
      .clock    (clock),
      .in_num   (front_work.num_y),
      .in_den   (front_work.den),
      .out_quot (quot[1]),
      .out_ovf  (ovf[1])
   );

   lpp_div u_div_z (
      .clock    (clock),
      .in_num   (front_work.num_z),
      .in_den   (front_work.den),
      .out_quot (quot[2]),
      .out_ovf  (ovf[2])
   );

   // Valid bits and side data travel in step with the dividers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            side_valid_ff[i] <= 1'b0;
         end
      end else begin
         side_valid_ff[0] <= front_valid;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_valid_ff[i] <= side_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= front_work.side;
      for (int i = 1; i < DIV_LAT; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // Output stage: signed offset, add to the line point and saturate; an in-plane line keeps its point.
   always_comb begin
      logic signed [COORD_W-1:0] base [3];
      logic signed [COORD_W-1:0] pt   [3];
      logic signed [SUM_W-1:0]   off;
      logic signed [SUM_W-1:0]   sum;
      logic signed [SUM_W-1:0]   sat_hi;
      logic signed [SUM_W-1:0]   sat_lo;
      logic                      neg;
      logic                      flag;
      lpp_side_type              side;
      side    = side_ff[DIV_LAT-1];
      base[0] = line_ff.point_x;
      base[1] = line_ff.point_y;
      base[2] = line_ff.point_z;
      sat_hi  = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
      sat_lo  = -sat_hi - SUM_W'(1);
      flag    = 1'b0;
      for (int i = 0; i < 3; i++) begin
         neg = side.neg[i];
         off = neg ? -SUM_W'(quot[i]) : SUM_W'(quot[i]);
         sum = SUM_W'(base[i]) + off;
         pt[i] = base[i];
         if (side.code != CASE_IN_PLANE) begin
            if (ovf[i]) begin
               pt[i] = neg ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
               flag  = 1'b1;
            end else if (sum > sat_hi) begin
               pt[i] = {1'b0, {(COORD_W-1){1'b1}}};
               flag  = 1'b1;
            end else if (sum < sat_lo) begin
               pt[i] = {1'b1, {(COORD_W-1){1'b0}}};
               flag  = 1'b1;
            end else begin
               pt[i] = sum[COORD_W-1:0];
            end
         end
      end
      rsp_data_in.proj_point_x = pt[0];
      rsp_data_in.proj_point_y = pt[1];
      rsp_data_in.proj_point_z = pt[2];
      rsp_data_in.proj_dir_x   = side.dir_x;
      rsp_data_in.proj_dir_y   = side.dir_y;
      rsp_data_in.proj_dir_z   = side.dir_z;
      rsp_data_in.case_code    = side.code;
      rsp_data_in.saturated    = flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= side_valid_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== sv/lpp_front.sv =====
// Six-stage front end: dot products, cross products, case decision and numerators.
`timescale 1ns / 1ps
`default_nettype none
module lpp_front
   import lpp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire lpp_req_type  in_req,
   input  wire lpp_line_type line,
   output logic              out_valid,
   output lpp_work_type      out_work
);

   logic signed [COORD_W-1:0] x [3];
   logic signed [DIR_W-1:0]   u [3];

   // Stage A: input capture.
   logic                      a_valid_ff;
   logic signed [COORD_W-1:0] a_p_ff [3];
   logic signed [DIR_W-1:0]   a_n_ff [3];

   // Stage B: offsets and pairwise products.
   logic                      b_valid_ff;
   logic signed [DIFF_W-1:0]  b_diff_ff [3], b_diff_in [3];
   logic signed [PROD_W-1:0]  b_un_ff [3], b_un_in [3];
   logic [PROD_W-1:0]         b_nn_ff [3], b_nn_in [3];
   logic signed [PROD_W-1:0]  b_cp_ff [6], b_cp_in [6];
   logic signed [DIR_W-1:0]   b_n_ff [3];

   // Stage C: sums, the products of offsets and normal, and the cross product u x n.
   logic                      c_valid_ff;
   logic signed [LPROD_W-1:0] c_lp_ff [3], c_lp_in [3];
   logic signed [UDN_W-1:0]   c_udn_ff, c_udn_in;
   logic [DEN_W-1:0]          c_nn_ff, c_nn_in;
   logic signed [CROSS_W-1:0] c_cr_ff [3], c_cr_in [3];
   logic signed [DIR_W-1:0]   c_n_ff [3];

   // Stage D: plane distance and the second cross product terms.
   logic                      d_valid_ff;
   logic signed [LTP_W-1:0]   d_ltp_ff, d_ltp_in;
   logic signed [DPROD_W-1:0] d_dp_ff [6], d_dp_in [6];
   logic signed [UDN_W-1:0]   d_udn_ff;
   logic [DEN_W-1:0]          d_nn_ff;
   logic signed [DIR_W-1:0]   d_n_ff [3];

   // Stage E: case decision, signs and magnitudes.
   logic                      e_valid_ff;
   logic [LTP_W-1:0]          e_lmag_ff, e_lmag_in;
   logic [DIR_W-1:0]          e_omag_ff [3], e_omag_in [3];
   logic [DEN_W-1:0]          e_den_ff, e_den_in;
   lpp_side_type              e_side_ff, e_side_in;

   // Stage F: numerators.
   logic                      f_valid_ff;
   lpp_work_type              f_work_ff, f_work_in;

   assign x[0] = line.point_x;
   assign x[1] = line.point_y;
   assign x[2] = line.point_z;
   assign u[0] = line.dir_x;
   assign u[1] = line.dir_y;
   assign u[2] = line.dir_z;

   // Valid bits for all stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   // Stage A capture.
   always_ff @(posedge clock) begin
      a_p_ff[0] <= in_req.plane_point_x;
      a_p_ff[1] <= in_req.plane_point_y;
      a_p_ff[2] <= in_req.plane_point_z;
      a_n_ff[0] <= in_req.normal_x;
      a_n_ff[1] <= in_req.normal_y;
      a_n_ff[2] <= in_req.normal_z;
   end

   // Stage B logic.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_diff_in[i] = DIFF_W'(a_p_ff[i]) - DIFF_W'(x[i]);
         b_un_in[i]   = PROD_W'(u[i]) * PROD_W'(a_n_ff[i]);
         b_nn_in[i]   = PROD_W'(a_n_ff[i]) * PROD_W'(a_n_ff[i]);
      end
      b_cp_in[0] = PROD_W'(u[1]) * PROD_W'(a_n_ff[2]);
      b_cp_in[1] = PROD_W'(u[2]) * PROD_W'(a_n_ff[1]);
      b_cp_in[2] = PROD_W'(u[2]) * PROD_W'(a_n_ff[0]);
      b_cp_in[3] = PROD_W'(u[0]) * PROD_W'(a_n_ff[2]);
      b_cp_in[4] = PROD_W'(u[0]) * PROD_W'(a_n_ff[1]);
      b_cp_in[5] = PROD_W'(u[1]) * PROD_W'(a_n_ff[0]);
   end

   always_ff @(posedge clock) begin
      b_diff_ff <= b_diff_in;
      b_un_ff   <= b_un_in;
      b_nn_ff   <= b_nn_in;
      b_cp_ff   <= b_cp_in;
      b_n_ff    <= a_n_ff;
   end

   // Stage C logic.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_lp_in[i] = LPROD_W'(b_diff_ff[i]) * LPROD_W'(b_n_ff[i]);
         c_cr_in[i] = CROSS_W'(b_cp_ff[2*i]) - CROSS_W'(b_cp_ff[2*i+1]);
      end
      c_udn_in = UDN_W'(b_un_ff[0]) + UDN_W'(b_un_ff[1]) + UDN_W'(b_un_ff[2]);
      c_nn_in  = b_nn_ff[0] + b_nn_ff[1] + b_nn_ff[2];
   end

   always_ff @(posedge clock) begin
      c_lp_ff  <= c_lp_in;
      c_cr_ff  <= c_cr_in;
      c_udn_ff <= c_udn_in;
      c_nn_ff  <= c_nn_in;
      c_n_ff   <= b_n_ff;
   end

   // Stage D logic: terms of n x (u x n).
   always_comb begin
      d_ltp_in  = LTP_W'(c_lp_ff[0]) + LTP_W'(c_lp_ff[1]) + LTP_W'(c_lp_ff[2]);
      d_dp_in[0] = DPROD_W'(c_n_ff[1]) * DPROD_W'(c_cr_ff[2]);
      d_dp_in[1] = DPROD_W'(c_n_ff[2]) * DPROD_W'(c_cr_ff[1]);
      d_dp_in[2] = DPROD_W'(c_n_ff[2]) * DPROD_W'(c_cr_ff[0]);
      d_dp_in[3] = DPROD_W'(c_n_ff[0]) * DPROD_W'(c_cr_ff[2]);
      d_dp_in[4] = DPROD_W'(c_n_ff[0]) * DPROD_W'(c_cr_ff[1]);
      d_dp_in[5] = DPROD_W'(c_n_ff[1]) * DPROD_W'(c_cr_ff[0]);
   end

   always_ff @(posedge clock) begin
      d_ltp_ff <= d_ltp_in;
      d_dp_ff  <= d_dp_in;
      d_udn_ff <= c_udn_ff;
      d_nn_ff  <= c_nn_ff;
      d_n_ff   <= c_n_ff;
   end

   // Stage E logic: pick the case, the divisor and the multiplier operands.
   always_comb begin
      logic                        intercept;
      logic                        ltp_neg;
      logic                        den_neg;
      logic signed [DIR_W-1:0]     op;
      logic signed [UDN_W-1:0]     udn_abs;
      logic signed [LTP_W-1:0]     ltp_abs;
      logic signed [DDIF_W-1:0]    dd [3];
      logic signed [DIR_OUT_W-1:0] dir [3];
      intercept = (d_udn_ff != '0);
      ltp_neg   = d_ltp_ff[LTP_W-1];
      den_neg   = intercept && d_udn_ff[UDN_W-1];
      udn_abs   = d_udn_ff[UDN_W-1] ? -d_udn_ff : d_udn_ff;
      ltp_abs   = ltp_neg ? -d_ltp_ff : d_ltp_ff;
      e_lmag_in = ltp_abs;
      e_den_in  = intercept ? udn_abs[DEN_W-1:0] : d_nn_ff;
      if (intercept) begin
         e_side_in.code = CASE_INTERCEPT;
      end else if (d_ltp_ff == '0) begin
         e_side_in.code = CASE_IN_PLANE;
      end else begin
         e_side_in.code = CASE_PARALLEL;
      end
      for (int i = 0; i < 3; i++) begin
         op = intercept ? u[i] : d_n_ff[i];
         e_omag_in[i] = op[DIR_W-1] ? DIR_W'(-op) : op;
         e_side_in.neg[i] = ltp_neg ^ op[DIR_W-1] ^ den_neg;
         dd[i] = DDIF_W'(d_dp_ff[2*i]) - DDIF_W'(d_dp_ff[2*i+1]);
         if (intercept) begin
            dir[i] = dd[i][DIR_OUT_W-1:0];
         end else begin
            dir[i] = DIR_OUT_W'(u[i]) <<< (2 * DIR_FRAC);
         end
      end
      e_side_in.dir_x = dir[0];
      e_side_in.dir_y = dir[1];
      e_side_in.dir_z = dir[2];
   end

   always_ff @(posedge clock) begin
      e_lmag_ff <= e_lmag_in;
      e_omag_ff <= e_omag_in;
      e_den_ff  <= e_den_in;
      e_side_ff <= e_side_in;
   end

   // Stage F logic: numerator magnitudes.
   always_comb begin
      f_work_in.num_x = NUM_W'(e_lmag_ff) * NUM_W'(e_omag_ff[0]);
      f_work_in.num_y = NUM_W'(e_lmag_ff) * NUM_W'(e_omag_ff[1]);
      f_work_in.num_z = NUM_W'(e_lmag_ff) * NUM_W'(e_omag_ff[2]);
      f_work_in.den   = e_den_ff;
      f_work_in.side  = e_side_ff;
   end

   always_ff @(posedge clock) begin
      f_work_ff <= f_work_in;
   end

   assign out_valid = f_valid_ff;
   assign out_work  = f_work_ff;

endmodule
`default_nettype wire

// ===== sv/lpp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`timescale 1ns / 1ps
`default_nettype none
module lpp_div
   import lpp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [DEN_W-1:0] in_den,
   output logic [QUOT_W-1:0]     out_quot,
   output logic                  out_ovf
);

   localparam int TOP_W = NUM_W - QUOT_W;

   logic [DEN_W-1:0]  rem_ff  [QUOT_W+1];
   logic [QUOT_W-1:0] low_ff  [QUOT_W+1];
   logic [QUOT_W-1:0] quot_ff [QUOT_W+1];
   logic [DEN_W-1:0]  den_ff  [QUOT_W+1];
   logic              ovf_ff  [QUOT_W+1];

   logic [TOP_W-1:0] top;

   // Entry stage: a quotient that needs more than QUOT_W bits is flagged.
   assign top = in_num[NUM_W-1:QUOT_W];

   always_ff @(posedge clock) begin
      rem_ff[0]  <= top[DEN_W-1:0];
      low_ff[0]  <= in_num[QUOT_W-1:0];
      quot_ff[0] <= '0;
      den_ff[0]  <= in_den;
      ovf_ff[0]  <= (top >= TOP_W'(in_den));
   end

   // One compare and subtract per stage.
   for (genvar k = 1; k <= QUOT_W; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;

      assign trial = {rem_ff[k-1], low_ff[k-1][QUOT_W-1]};
      assign diff  = trial - {1'b0, den_ff[k-1]};
      assign ge    = (trial >= {1'b0, den_ff[k-1]});

      always_ff @(posedge clock) begin
         rem_ff[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         low_ff[k]  <= {low_ff[k-1][QUOT_W-2:0], 1'b0};
         quot_ff[k] <= {quot_ff[k-1][QUOT_W-2:0], ge};
         den_ff[k]  <= den_ff[k-1];
         ovf_ff[k]  <= ovf_ff[k-1];
      end
   end

   assign out_quot = quot_ff[QUOT_W];
   assign out_ovf  = ovf_ff[QUOT_W];

endmodule
`default_nettype wire
